// File: src/tss_pkg.sv
package tss_pkg;

  localparam int QUEUE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int TIME_W      = 18;
  localparam int TONE_MAX    = 6000;
  localparam int MIN_TIME    = 5;

  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_ENQUEUE = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic               func;
    logic [15:0]        elapsed;
    logic signed [15:0] tone;
    logic [15:0]        beep_time;
    logic [15:0]        pause_time;
  } in_item_t;

  typedef struct packed {
    logic               beeper_on;
    logic signed [15:0] active_tone;
    logic [13:0]        pwm_period;
    logic [12:0]        pwm_compare;
    logic               queue_empty;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0]       tone;
    logic signed [TIME_W-1:0] beep;
    logic signed [TIME_W-1:0] delay;
  } task_t;

  typedef struct packed {
    logic               apply;
    logic signed [15:0] tone;
  } tone_req_t;

  typedef struct packed {
    logic signed [15:0] tone;
    logic [13:0]        period;
    logic [12:0]        compare;
  } tone_stat_t;

  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    task_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } ram_req_t;

  function automatic idx_t next_index(idx_t i);
    if (i == idx_t'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return i + idx_t'(1);
  endfunction

endpackage

// File: src/tone_sequence_scheduler_top.sv
// An enqueue or an empty-queue tick gives its result in the cycle after the transfer;
// a tick on a queued task first reads the head entry into a register (state ST_EXEC), then registers its result.
// Throughput: one enqueue or empty-queue tick per cycle, with out_ready high; a tick on a queued task
// holds in_ready low while the head entry is read and updated in ST_EXEC.
// Reset: synchronous, active low; clears head, tail, tone and PWM registers.
// The task RAM is not cleared; only written entries are ever read.
module tone_sequence_scheduler_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tss_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tss_pkg::out_item_t out_data
);
  import tss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  idx_t        head_r, head_nxt;
  idx_t        tail_r, tail_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        overflow_r, overflow_nxt;

  logic       accept;
  logic       q_empty;
  logic       q_full;
  ram_req_t   ram_req;
  task_t      rd_task;
  task_t      upd_task;
  tone_req_t  tone_req;
  tone_stat_t tone_stat;
  logic signed [TIME_W-1:0] el_ext;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign q_empty  = (head_r == tail_r);
  assign q_full   = (next_index(tail_r) == head_r);
  assign el_ext   = $signed({{(TIME_W-16){1'b0}}, elapsed_r});

  tss_task_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_task)
  );

  tss_tone_unit u_tone (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tone_req),
    .stat  (tone_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    elapsed_nxt   = elapsed_r;
    out_valid_nxt = out_valid_r && !out_ready;
    overflow_nxt  = overflow_r;
    ram_req       = '0;
    tone_req      = '0;
    upd_task      = rd_task;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_ENQUEUE) begin
            out_valid_nxt = 1'b1;
            if (q_full) begin
              overflow_nxt = 1'b1;
            end else begin
              overflow_nxt        = 1'b0;
              ram_req.wr_en       = 1'b1;
              ram_req.wr_addr     = tail_r;
              ram_req.wr_data.tone  = in_data.tone;
              ram_req.wr_data.beep  = (in_data.beep_time > 16'(MIN_TIME)) ?
                  $signed({{(TIME_W-16){1'b0}}, in_data.beep_time}) : TIME_W'(MIN_TIME);
              ram_req.wr_data.delay = (in_data.pause_time > 16'(MIN_TIME)) ?
                  $signed({{(TIME_W-16){1'b0}}, in_data.pause_time}) : TIME_W'(MIN_TIME);
              tail_nxt            = next_index(tail_r);
            end
          end else begin
            overflow_nxt = 1'b0;
            if (q_empty) begin
              tone_req.apply = 1'b1;
              out_valid_nxt  = 1'b1;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = head_r;
              elapsed_nxt     = in_data.elapsed;
              state_nxt       = ST_EXEC;
            end
          end
        end
      end
      ST_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (rd_task.delay > 0) begin
          upd_task.delay  = rd_task.delay - el_ext;
          tone_req.apply  = 1'b1;
          ram_req.wr_en   = 1'b1;
        end else if (rd_task.beep > 0) begin
          upd_task.beep   = rd_task.beep - el_ext;
          tone_req.apply  = 1'b1;
          tone_req.tone   = rd_task.tone;
          ram_req.wr_en   = 1'b1;
        end else begin
          head_nxt = next_index(head_r);
        end
        ram_req.wr_addr = head_r;
        ram_req.wr_data = upd_task;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
      overflow_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
      overflow_r  <= overflow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r <= elapsed_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_data.beeper_on   = (tone_stat.tone != '0);
  assign out_data.active_tone = tone_stat.tone;
  assign out_data.pwm_period  = tone_stat.period;
  assign out_data.pwm_compare = tone_stat.compare;
  assign out_data.queue_empty = q_empty;
  assign out_data.overflow    = overflow_r;

endmodule

// File: src/tss_task_ram.sv
module tss_task_ram (
  input  logic              clk,
  input  tss_pkg::ram_req_t req,
  output tss_pkg::task_t    rd_data
);
  import tss_pkg::*;

  task_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// File: src/tss_tone_unit.sv
module tss_tone_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  tss_pkg::tone_req_t  req,
  output tss_pkg::tone_stat_t stat
);
  import tss_pkg::*;

  logic signed [15:0] cur_tone_r, cur_tone_nxt;
  logic [13:0]        period_r, period_nxt;
  logic [12:0]        compare_r, compare_nxt;
  logic signed [17:0] diff;
  logic [12:0]        x;

  always_comb begin
    diff = 18'(TONE_MAX) - {{2{req.tone[15]}}, req.tone};
    if (diff < 0) begin
      x = '0;
    end else if (diff > 18'(TONE_MAX)) begin
      x = 13'(TONE_MAX);
    end else begin
      x = diff[12:0];
    end
  end

  always_comb begin
    cur_tone_nxt = cur_tone_r;
    period_nxt   = period_r;
    compare_nxt  = compare_r;
    if (req.apply && (req.tone != cur_tone_r)) begin
      cur_tone_nxt = req.tone;
      if (req.tone != '0) begin
        compare_nxt = x;
        period_nxt  = {x, 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_tone_r <= '0;
      period_r   <= '0;
      compare_r  <= '0;
    end else begin
      cur_tone_r <= cur_tone_nxt;
      period_r   <= period_nxt;
      compare_r  <= compare_nxt;
    end
  end

  assign stat.tone    = cur_tone_r;
  assign stat.period  = period_r;
  assign stat.compare = compare_r;

endmodule

// File: src/tss_checker.sv
module tss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tss_pkg::out_item_t out_data
);
  import tss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_beeper_tone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.beeper_on == (out_data.active_tone != '0)))
    else $error("beeper state disagrees with active tone");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> !out_data.queue_empty)
    else $error("overflow flagged on an empty queue");

  a_pwm_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.beeper_on |->
      (out_data.pwm_period == {out_data.pwm_compare, 1'b0}))
    else $error("pwm period is not twice the compare value");

endmodule

bind tone_sequence_scheduler_top tss_checker u_tss_checker (.*);
